@@ rtl/core/obmm_pkg.sv @@
// shared types, codes and constants of the order book metrics block
package obmm_pkg;

    localparam int PRICE_WIDTH_DEF = 32;
    localparam int QTY_W           = 32;
    localparam int S_TDATA_W       = 200;
    localparam int M_TDATA_W       = 648;
    localparam int STATUS_W        = 3;
    localparam int WIDE_W          = 128;
    localparam int PX_W            = 46;
    localparam int VOL_W           = 55;
    localparam int CNT_W           = 64;

    localparam logic [STATUS_W-1:0] STAT_BOOK_IGNORED = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_BOOK_DEGEN   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_BOOK_TAKEN   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_TRADE_IGNORED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_TRADE_TAKEN  = 3'd4;

    localparam logic [WIDE_W-1:0] K_SCALE_E12 = 128'd1000000000000;
    localparam logic [WIDE_W-1:0] K_MICRO     = 128'd10000;
    localparam logic [63:0]       K_MID       = 64'd5000;
    localparam logic [WIDE_W-1:0] K_LAMBDA    = 128'd50000000;
    localparam logic [WIDE_W-1:0] K_VOL       = 128'd1000;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_DECODE = 9'b000000010,
        ST_ISSUE  = 9'b000000100,
        ST_MUL    = 9'b000001000,
        ST_DIV    = 9'b000010000,
        ST_FIX    = 9'b000100000,
        ST_ROOT   = 9'b001000000,
        ST_POST   = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_UDIV,
        OP_SDIV,
        OP_ROOT
    } op_t;

    typedef enum logic [4:0] {
        STEP_BK_MUL1,
        STEP_BK_MUL2,
        STEP_BK_MUL3,
        STEP_BK_DIV,
        STEP_RT_MUL,
        STEP_RT_DIV,
        STEP_L_MUL2,
        STEP_L_DIV2,
        STEP_L_HALF,
        STEP_L_MUL3,
        STEP_L_DIV3,
        STEP_L_THIRD,
        STEP_L_MUL4,
        STEP_L_DIV4,
        STEP_L_QUART,
        STEP_SQ_MUL,
        STEP_SQ_ROOT,
        STEP_SQ_DIV,
        STEP_TR_MUL1,
        STEP_TR_MUL2,
        STEP_TR_MUL3,
        STEP_TR_DIV
    } step_t;

endpackage

@@ rtl/core/order_book_microstructure_metrics.sv @@
// order book metrics: microprice, flow imbalance, volatility, spread, lambda
//
// one event per input transfer: s_tuser is the opcode (0 book, 1 trade),
// s_tdata carries bid price/size, ask price/size, trade price/size and the
// buyer flag. one result transfer per event: m_tuser is the status code,
// m_tdata the eleven metric values as they stand after the event.
// events are handled one at a time by a sequencer that drives a shared
// bit-serial unit: shift-add multiply (one multiplier bit a cycle, stops when
// the rest is zero), restoring divide (with sign fix) and square
// root (two radicand bits a cycle).
// ignored books, degenerate books, ignored and first trades skip the arithmetic;
// a book without a mid move runs three multiplies and a divide, one with a mid
// move also the return, log series and volatility steps (nine 128-bit divides);
// a trade two multiplies, and a third and a divide unless its volume sum stays zero.
// s_tready is high only between events.
// a finished result sits in the output register; the next event is taken
// while it waits, and its own result waits in the sequencer until m_tready.
// reset clears all metrics, sums and the stored book.
module order_book_microstructure_metrics
    import obmm_pkg::*;
#(
    parameter int PRICE_WIDTH = PRICE_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // bid_price, bid_quantity, ask_price, ask_quantity, trade_price,
    // trade_quantity, buy_side, zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // opcode
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // microprice, mid_price, micro_minus_mid, flow_imbalance,
    // realized_volatility, return_sample_count, book_update_count,
    // degenerate_count, trade_count, spread_sum, kyle_lambda, zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    // status
    output logic [STATUS_W-1:0]  m_tuser
);

    localparam int MIDW = PRICE_WIDTH + 1;

    state_t state_reg, state_next;
    step_t  step_reg;
    logic   negq_reg;
    logic [6:0] cnt_reg;
    logic [WIDE_W-1:0] a_reg, b_reg, p_reg, r_reg;
    logic [WIDE_W-1:0] t_reg, x_reg, y_reg, acc_reg;

    logic                   op_in_reg, buy_reg;
    logic [PRICE_WIDTH-1:0] bp_reg, ap_reg, tp_reg;
    logic [QTY_W-1:0]       bq_reg, aq_reg, tq_reg;

    logic [PRICE_WIDTH-1:0] lbp_reg, lap_reg;
    logic [QTY_W-1:0]       lbs_reg, las_reg;
    logic                   have_book_reg;
    logic [MIDW-1:0]        prior_mid_reg, prior_tmid_reg;
    logic [WIDE_W-1:0]      sq_sum_reg, pv_sum_reg, vs_sum_reg;
    logic [PX_W-1:0]        micro_reg, mid_reg, diff_reg;
    logic [CNT_W-1:0]       imb_reg, samples_reg, books_reg, degen_reg;
    logic [CNT_W-1:0]       trades_reg, spread_reg, lambda_reg;
    logic [VOL_W-1:0]       vol_reg;
    logic [STATUS_W-1:0]    status_reg;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [STATUS_W-1:0]  m_user_reg;

    logic [MIDW-1:0]   midx2, tmid2, px2;
    logic [MIDW:0]     mid_d, tdp;
    logic [63:0]       v64, imb_e, spread_inc;
    logic [PX_W-1:0]   mid_val;
    logic              book_zero, book_degen, trade_bad, ret_cond, dec_issue;
    logic              fin_book, fin_trade;
    logic [WIDE_W-1:0] vs_new;
    logic [WIDE_W-1:0] iss_a, iss_b;
    op_t               iss_op;
    logic [WIDE_W:0]   div_rsh, div_diff;
    logic              div_take;
    logic [66:0]       rt_rsh, rt_trial;
    logic [67:0]       rt_diff;
    logic              rt_take;

    assign midx2 = {1'b0, bp_reg} + {1'b0, ap_reg};
    assign tmid2 = {1'b0, lbp_reg} + {1'b0, lap_reg};
    assign px2   = {tp_reg, 1'b0};
    assign mid_d = {1'b0, midx2} - {1'b0, prior_mid_reg};
    assign tdp   = {1'b0, tmid2} - {1'b0, prior_tmid_reg};
    assign v64   = buy_reg ? {32'd0, tq_reg} : 64'd0 - {32'd0, tq_reg};
    assign mid_val = PX_W'(64'(midx2) * K_MID);
    assign spread_inc = (px2 >= tmid2) ? 64'(px2 - tmid2) : 64'(tmid2 - px2);
    assign imb_e = ((bp_reg >= lbp_reg) ? 64'(bq_reg) : 64'd0)
                 - ((bp_reg <= lbp_reg) ? 64'(lbs_reg) : 64'd0)
                 - ((ap_reg <= lap_reg) ? 64'(aq_reg) : 64'd0)
                 + ((ap_reg >= lap_reg) ? 64'(las_reg) : 64'd0);

    assign book_zero  = (bp_reg == '0) || (ap_reg == '0) || (bq_reg == '0) || (aq_reg == '0);
    assign book_degen = bp_reg >= ap_reg;
    assign trade_bad  = !have_book_reg || (lbp_reg == '0) || (lap_reg == '0);
    assign ret_cond   = have_book_reg && (prior_mid_reg != '0) && (midx2 != prior_mid_reg);
    assign dec_issue  = op_in_reg ? (!trade_bad && (prior_tmid_reg != '0))
                                  : (!book_zero && !book_degen);
    assign vs_new     = vs_sum_reg + p_reg;

    assign fin_book  = (state_reg == ST_POST) &&
                       (((step_reg == STEP_BK_DIV) && !ret_cond) || (step_reg == STEP_SQ_DIV));
    assign fin_trade = (state_reg == ST_POST) &&
                       (((step_reg == STEP_TR_MUL2) && (vs_new == '0)) ||
                        (step_reg == STEP_TR_DIV));

    // operands of each sequencer step
    always_comb begin
        iss_a  = t_reg;
        iss_b  = K_SCALE_E12;
        iss_op = OP_SDIV;
        unique case (step_reg)
            STEP_BK_MUL1: begin
                iss_a = WIDE_W'(bp_reg); iss_b = WIDE_W'(aq_reg); iss_op = OP_MUL;
            end
            STEP_BK_MUL2: begin
                iss_a = WIDE_W'(ap_reg); iss_b = WIDE_W'(bq_reg); iss_op = OP_MUL;
            end
            STEP_BK_MUL3: begin
                iss_a = t_reg; iss_b = K_MICRO; iss_op = OP_MUL;
            end
            STEP_BK_DIV: begin
                iss_a = t_reg; iss_b = WIDE_W'(bq_reg) + WIDE_W'(aq_reg); iss_op = OP_UDIV;
            end
            STEP_RT_MUL: begin
                iss_a = {{(WIDE_W-MIDW-1){mid_d[MIDW]}}, mid_d};
                iss_b = K_SCALE_E12; iss_op = OP_MUL;
            end
            STEP_RT_DIV: begin
                iss_a = t_reg; iss_b = WIDE_W'(prior_mid_reg); iss_op = OP_SDIV;
            end
            STEP_L_MUL2: begin
                iss_a = x_reg; iss_b = x_reg; iss_op = OP_MUL;
            end
            STEP_L_DIV2, STEP_L_DIV3, STEP_L_DIV4: begin
                iss_a = t_reg; iss_b = K_SCALE_E12; iss_op = OP_SDIV;
            end
            STEP_L_HALF: begin
                iss_a = y_reg; iss_b = 128'd2; iss_op = OP_SDIV;
            end
            STEP_L_MUL3, STEP_L_MUL4: begin
                iss_a = y_reg; iss_b = x_reg; iss_op = OP_MUL;
            end
            STEP_L_THIRD: begin
                iss_a = y_reg; iss_b = 128'd3; iss_op = OP_SDIV;
            end
            STEP_L_QUART: begin
                iss_a = y_reg; iss_b = 128'd4; iss_op = OP_SDIV;
            end
            STEP_SQ_MUL: begin
                iss_a = {{64{acc_reg[63]}}, acc_reg[63:0]};
                iss_b = {{64{acc_reg[63]}}, acc_reg[63:0]};
                iss_op = OP_MUL;
            end
            STEP_SQ_ROOT: begin
                iss_a = sq_sum_reg; iss_b = '0; iss_op = OP_ROOT;
            end
            STEP_SQ_DIV: begin
                iss_a = t_reg; iss_b = K_VOL; iss_op = OP_UDIV;
            end
            STEP_TR_MUL1: begin
                iss_a = {{(WIDE_W-MIDW-1){tdp[MIDW]}}, tdp};
                iss_b = {{64{v64[63]}}, v64}; iss_op = OP_MUL;
            end
            STEP_TR_MUL2: begin
                iss_a = WIDE_W'(tq_reg); iss_b = WIDE_W'(tq_reg); iss_op = OP_MUL;
            end
            STEP_TR_MUL3: begin
                iss_a = pv_sum_reg; iss_b = K_LAMBDA; iss_op = OP_MUL;
            end
            STEP_TR_DIV: begin
                iss_a = t_reg; iss_b = vs_sum_reg; iss_op = OP_SDIV;
            end
            default: begin
                iss_a = t_reg; iss_b = K_SCALE_E12; iss_op = OP_SDIV;
            end
        endcase
    end

    // restoring divide digit and square root digit
    assign div_rsh  = {r_reg, a_reg[WIDE_W-1]};
    assign div_diff = div_rsh - {1'b0, b_reg};
    assign div_take = !div_diff[WIDE_W];
    assign rt_rsh   = {r_reg[64:0], a_reg[WIDE_W-1:WIDE_W-2]};
    assign rt_trial = {1'b0, p_reg[63:0], 2'b01};
    assign rt_diff  = {1'b0, rt_rsh} - {1'b0, rt_trial};
    assign rt_take  = !rt_diff[67];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_DECODE;
            ST_DECODE: state_next = dec_issue ? ST_ISSUE : ST_OUT;
            ST_ISSUE: begin
                unique case (iss_op)
                    OP_MUL:  state_next = ST_MUL;
                    OP_UDIV: state_next = ST_DIV;
                    OP_SDIV: state_next = ST_DIV;
                    OP_ROOT: state_next = ST_ROOT;
                    default: state_next = ST_MUL;
                endcase
            end
            ST_MUL:  if (b_reg == '0) state_next = ST_POST;
            ST_DIV:  if (cnt_reg == 7'd127) state_next = ST_FIX;
            ST_FIX:  state_next = ST_POST;
            ST_ROOT: if (cnt_reg == 7'd63) state_next = ST_POST;
            ST_POST: state_next = (fin_book || fin_trade) ? ST_OUT : ST_ISSUE;
            ST_OUT:  if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            lbp_reg        <= '0;
            lap_reg        <= '0;
            lbs_reg        <= '0;
            las_reg        <= '0;
            have_book_reg  <= 1'b0;
            prior_mid_reg  <= '0;
            prior_tmid_reg <= '0;
            sq_sum_reg     <= '0;
            pv_sum_reg     <= '0;
            vs_sum_reg     <= '0;
            micro_reg      <= '0;
            mid_reg        <= '0;
            diff_reg       <= '0;
            imb_reg        <= '0;
            vol_reg        <= '0;
            samples_reg    <= '0;
            books_reg      <= '0;
            degen_reg      <= '0;
            trades_reg     <= '0;
            spread_reg     <= '0;
            lambda_reg     <= '0;
        end else begin
            state_reg <= state_next;

            if (m_valid_reg && m_tready && (state_reg != ST_OUT)) m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_in_reg <= s_tuser;
                        bp_reg    <= s_tdata[PRICE_WIDTH-1:0];
                        bq_reg    <= s_tdata[63:32];
                        ap_reg    <= s_tdata[64 +: PRICE_WIDTH];
                        aq_reg    <= s_tdata[127:96];
                        tp_reg    <= s_tdata[128 +: PRICE_WIDTH];
                        tq_reg    <= s_tdata[191:160];
                        buy_reg   <= s_tdata[192];
                    end
                end
                ST_DECODE: begin
                    if (!op_in_reg) begin
                        if (book_zero) begin
                            status_reg <= STAT_BOOK_IGNORED;
                        end else if (book_degen) begin
                            degen_reg  <= degen_reg + 64'd1;
                            status_reg <= STAT_BOOK_DEGEN;
                        end else begin
                            books_reg <= books_reg + 64'd1;
                            step_reg  <= STEP_BK_MUL1;
                        end
                    end else begin
                        if (trade_bad) begin
                            status_reg <= STAT_TRADE_IGNORED;
                        end else begin
                            trades_reg <= trades_reg + 64'd1;
                            spread_reg <= spread_reg + spread_inc;
                            if (prior_tmid_reg == '0) begin
                                prior_tmid_reg <= tmid2;
                                status_reg     <= STAT_TRADE_TAKEN;
                            end else begin
                                step_reg <= STEP_TR_MUL1;
                            end
                        end
                    end
                end
                ST_ISSUE: begin
                    p_reg   <= '0;
                    r_reg   <= '0;
                    cnt_reg <= '0;
                    unique case (iss_op)
                        OP_SDIV: begin
                            a_reg    <= iss_a[WIDE_W-1] ? -iss_a : iss_a;
                            b_reg    <= iss_b[WIDE_W-1] ? -iss_b : iss_b;
                            negq_reg <= iss_a[WIDE_W-1] ^ iss_b[WIDE_W-1];
                        end
                        OP_UDIV: begin
                            a_reg    <= iss_a;
                            b_reg    <= iss_b;
                            negq_reg <= 1'b0;
                        end
                        OP_MUL: begin
                            a_reg <= iss_a;
                            b_reg <= iss_b;
                        end
                        OP_ROOT: begin
                            a_reg <= iss_a;
                        end
                        default: a_reg <= iss_a;
                    endcase
                end
                ST_MUL: begin
                    if (b_reg != '0) begin
                        if (b_reg[0]) p_reg <= p_reg + a_reg;
                        a_reg <= {a_reg[WIDE_W-2:0], 1'b0};
                        b_reg <= {1'b0, b_reg[WIDE_W-1:1]};
                    end
                end
                ST_DIV: begin
                    r_reg   <= div_take ? div_diff[WIDE_W-1:0] : div_rsh[WIDE_W-1:0];
                    a_reg   <= {a_reg[WIDE_W-2:0], div_take};
                    cnt_reg <= cnt_reg + 7'd1;
                end
                ST_FIX: begin
                    p_reg <= negq_reg ? -a_reg : a_reg;
                end
                ST_ROOT: begin
                    r_reg   <= WIDE_W'(rt_take ? rt_diff[66:0] : rt_rsh);
                    p_reg   <= {p_reg[WIDE_W-2:0], rt_take};
                    a_reg   <= {a_reg[WIDE_W-3:0], 2'b00};
                    cnt_reg <= cnt_reg + 7'd1;
                end
                ST_POST: begin
                    unique case (step_reg)
                        STEP_BK_MUL1: begin t_reg <= p_reg; step_reg <= STEP_BK_MUL2; end
                        STEP_BK_MUL2: begin
                            t_reg <= t_reg + p_reg; step_reg <= STEP_BK_MUL3;
                        end
                        STEP_BK_MUL3: begin t_reg <= p_reg; step_reg <= STEP_BK_DIV; end
                        STEP_BK_DIV: begin
                            micro_reg <= p_reg[PX_W-1:0];
                            mid_reg   <= mid_val;
                            diff_reg  <= p_reg[PX_W-1:0] - mid_val;
                            if (have_book_reg) imb_reg <= imb_reg + imb_e;
                            step_reg <= STEP_RT_MUL;
                        end
                        STEP_RT_MUL: begin t_reg <= p_reg; step_reg <= STEP_RT_DIV; end
                        STEP_RT_DIV: begin
                            x_reg    <= {{64{p_reg[63]}}, p_reg[63:0]};
                            acc_reg  <= {{64{p_reg[63]}}, p_reg[63:0]};
                            step_reg <= STEP_L_MUL2;
                        end
                        STEP_L_MUL2: begin t_reg <= p_reg; step_reg <= STEP_L_DIV2; end
                        STEP_L_DIV2: begin y_reg <= p_reg; step_reg <= STEP_L_HALF; end
                        STEP_L_HALF: begin
                            acc_reg <= acc_reg - p_reg; step_reg <= STEP_L_MUL3;
                        end
                        STEP_L_MUL3: begin t_reg <= p_reg; step_reg <= STEP_L_DIV3; end
                        STEP_L_DIV3: begin y_reg <= p_reg; step_reg <= STEP_L_THIRD; end
                        STEP_L_THIRD: begin
                            acc_reg <= acc_reg + p_reg; step_reg <= STEP_L_MUL4;
                        end
                        STEP_L_MUL4: begin t_reg <= p_reg; step_reg <= STEP_L_DIV4; end
                        STEP_L_DIV4: begin y_reg <= p_reg; step_reg <= STEP_L_QUART; end
                        STEP_L_QUART: begin
                            acc_reg <= acc_reg - p_reg; step_reg <= STEP_SQ_MUL;
                        end
                        STEP_SQ_MUL: begin
                            sq_sum_reg  <= sq_sum_reg + p_reg;
                            samples_reg <= samples_reg + 64'd1;
                            step_reg    <= STEP_SQ_ROOT;
                        end
                        STEP_SQ_ROOT: begin t_reg <= p_reg; step_reg <= STEP_SQ_DIV; end
                        STEP_SQ_DIV:  vol_reg <= p_reg[VOL_W-1:0];
                        STEP_TR_MUL1: begin
                            pv_sum_reg <= pv_sum_reg + p_reg; step_reg <= STEP_TR_MUL2;
                        end
                        STEP_TR_MUL2: begin
                            vs_sum_reg <= vs_new; step_reg <= STEP_TR_MUL3;
                        end
                        STEP_TR_MUL3: begin t_reg <= p_reg; step_reg <= STEP_TR_DIV; end
                        STEP_TR_DIV:  lambda_reg <= p_reg[CNT_W-1:0];
                        default: step_reg <= STEP_BK_MUL1;
                    endcase
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_user_reg  <= status_reg;
                        m_data_reg  <= {7'd0, lambda_reg, spread_reg, trades_reg, degen_reg,
                                        books_reg, samples_reg, vol_reg, imb_reg, diff_reg,
                                        mid_reg, micro_reg};
                    end
                end
                default: ;
            endcase

            if (fin_book) begin
                prior_mid_reg <= midx2;
                lbp_reg       <= bp_reg;
                lbs_reg       <= bq_reg;
                lap_reg       <= ap_reg;
                las_reg       <= aq_reg;
                have_book_reg <= 1'b1;
                status_reg    <= STAT_BOOK_TAKEN;
            end
            if (fin_trade) begin
                prior_tmid_reg <= tmid2;
                status_reg     <= STAT_TRADE_TAKEN;
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

@@ rtl/core/obmm_checker.sv @@
// port-level checks of the order book metrics block and their binding
module obmm_checker
    import obmm_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    // no result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // status code in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= STAT_TRADE_TAKEN))
        else $error("status code out of range");

    // one event in flight: busy after an input transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // every result leaves the zero fill clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:641] == '0))
        else $error("result fill bits set");

endmodule

bind order_book_microstructure_metrics obmm_checker u_obmm_checker (.*);

@@ tb/sv/order_book_microstructure_metrics_tb.sv @@
// testbench for the order book metrics block: random and directed events against a predictor
`timescale 1ns / 1ps

module order_book_microstructure_metrics_tb;
    import obmm_pkg::*;

    localparam int NFIELD = 11;
    localparam int MET_W  = 641;
    localparam int FOFF [NFIELD] = '{0, 46, 92, 138, 202, 257, 321, 385, 449, 513, 577};
    localparam int FWID [NFIELD] = '{46, 46, 46, 64, 55, 64, 64, 64, 64, 64, 64};
    localparam string FNAME [NFIELD] = '{"microprice", "mid_price", "micro_minus_mid",
        "flow_imbalance", "realized_volatility", "return_sample_count",
        "book_update_count", "degenerate_count", "trade_count", "spread_sum",
        "kyle_lambda"};
    localparam logic OPC_BOOK  = 1'b0;
    localparam logic OPC_TRADE = 1'b1;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    order_book_microstructure_metrics i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // predictor state
    logic [31:0]  bk_bid_px, bk_bid_qty, bk_ask_px, bk_ask_qty;
    logic         bk_valid;
    logic [63:0]  mid2_prev, trade_mid2_prev;
    logic [127:0] sq_ret_sum, px_vol_sum, vol_sq_sum;
    logic [45:0]  p_micro, p_mid, p_diff;
    logic [63:0]  p_imb, p_vol, p_samples, p_books, p_degen, p_trades, p_spread, p_lambda;

    logic [STATUS_W-1:0] status_q [$];
    logic [MET_W-1:0]    metrics_q [$];

    int  fail_count;
    bit  calm;
    int  hold_cycles;
    int unsigned walk_px;

    function automatic logic [127:0] sext64(logic [63:0] v);
        return {{64{v[63]}}, v};
    endfunction

    function automatic logic [127:0] sdiv_trunc(logic [127:0] n, logic [127:0] d);
        logic [127:0] an, ad, q;
        an = n[127] ? -n : n;
        ad = d[127] ? -d : d;
        q  = (ad == 0) ? 128'd0 : an / ad;
        return (n[127] != d[127]) ? -q : q;
    endfunction

    function automatic logic [63:0] log1p_4(logic [63:0] x);
        logic [127:0] xw, x2, x3, x4, r;
        xw = sext64(x);
        x2 = sdiv_trunc(xw * xw, K_SCALE_E12);
        x3 = sdiv_trunc(x2 * xw, K_SCALE_E12);
        x4 = sdiv_trunc(x3 * xw, K_SCALE_E12);
        r  = xw - sdiv_trunc(x2, 128'd2) + sdiv_trunc(x3, 128'd3) - sdiv_trunc(x4, 128'd4);
        return r[63:0];
    endfunction

    function automatic logic [63:0] isqrt128(logic [127:0] v);
        logic [63:0]  res, c;
        logic [127:0] sq;
        res = '0;
        for (int b = 63; b >= 0; b--) begin
            c  = res | (64'd1 << b);
            sq = {64'd0, c} * {64'd0, c};
            if (v >= sq) res = c;
        end
        return res;
    endfunction

    task automatic predict_book(input logic [31:0] bp, bq, ap, aq,
                                output logic [STATUS_W-1:0] st);
        logic [127:0] num, num2;
        logic [63:0]  mid2, flow, x, r;
        if (bp == 0 || bq == 0 || ap == 0 || aq == 0) begin
            st = STAT_BOOK_IGNORED;
        end else if (bp >= ap) begin
            st = STAT_BOOK_DEGEN;
            p_degen++;
        end else begin
            st = STAT_BOOK_TAKEN;
            p_books++;
            num = ({96'd0, bp} * {96'd0, aq} + {96'd0, ap} * {96'd0, bq}) * K_MICRO;
            num = num / ({96'd0, bq} + {96'd0, aq});
            p_micro = num[45:0];
            mid2 = {32'd0, bp} + {32'd0, ap};
            num = {64'd0, mid2 * K_MID};
            p_mid = num[45:0];
            p_diff = p_micro - p_mid;
            if (bk_valid) begin
                flow = '0;
                if (bp >= bk_bid_px) flow += {32'd0, bq};
                if (bp <= bk_bid_px) flow -= {32'd0, bk_bid_qty};
                if (ap <= bk_ask_px) flow -= {32'd0, aq};
                if (ap >= bk_ask_px) flow += {32'd0, bk_ask_qty};
                p_imb += flow;
                if (mid2_prev > 0 && mid2 != mid2_prev) begin
                    num2 = sext64(mid2 - mid2_prev) * K_SCALE_E12;
                    num2 = sdiv_trunc(num2, {64'd0, mid2_prev});
                    x = num2[63:0];
                    r = log1p_4(x);
                    sq_ret_sum += sext64(r) * sext64(r);
                    p_samples++;
                    p_vol = isqrt128(sq_ret_sum) / 64'd1000;
                end
            end else begin
                bk_valid = 1'b1;
            end
            mid2_prev  = mid2;
            bk_bid_px  = bp;
            bk_bid_qty = bq;
            bk_ask_px  = ap;
            bk_ask_qty = aq;
        end
    endtask

    task automatic predict_trade(input logic [31:0] tp, tq, input logic buy,
                                 output logic [STATUS_W-1:0] st);
        logic [63:0]  mid2, px2, vol;
        logic [127:0] q;
        if (!bk_valid || bk_bid_px == 0 || bk_ask_px == 0) begin
            st = STAT_TRADE_IGNORED;
        end else begin
            st = STAT_TRADE_TAKEN;
            p_trades++;
            mid2 = {32'd0, bk_bid_px} + {32'd0, bk_ask_px};
            px2 = {31'd0, tp, 1'b0};
            p_spread += (px2 >= mid2) ? px2 - mid2 : mid2 - px2;
            vol = buy ? {32'd0, tq} : 64'd0 - {32'd0, tq};
            if (trade_mid2_prev > 0) begin
                px_vol_sum += sext64(mid2 - trade_mid2_prev) * sext64(vol);
                vol_sq_sum += {96'd0, tq} * {96'd0, tq};
                if (vol_sq_sum != 0) begin
                    q = sdiv_trunc(px_vol_sum * K_LAMBDA, vol_sq_sum);
                    p_lambda = q[63:0];
                end
            end
            trade_mid2_prev = mid2;
        end
    endtask

    task automatic send_event(input logic opc, input logic [31:0] bp, bq, ap, aq, tp, tq,
                              input logic buy);
        logic [STATUS_W-1:0] st;
        if (!calm && $urandom_range(0, 99) < 13) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= opc;
        s_tdata  <= {7'd0, buy, tq, tp, aq, ap, bq, bp};
        do @(posedge aclk); while (!s_tready);
        if (opc == OPC_BOOK) predict_book(bp, bq, ap, aq, st);
        else predict_trade(tp, tq, buy, st);
        status_q.push_back(st);
        metrics_q.push_back({p_lambda, p_spread, p_trades, p_degen, p_books, p_samples,
                             p_vol[54:0], p_imb, p_diff, p_mid, p_micro});
    endtask

    task automatic send_book(input logic [31:0] bp, bq, ap, aq);
        send_event(OPC_BOOK, bp, bq, ap, aq, $urandom, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_trade(input logic [31:0] tp, tq, input logic buy);
        send_event(OPC_TRADE, $urandom, $urandom, $urandom, $urandom, tp, tq, buy);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (status_q.size() != 0) @(posedge aclk);
    endtask

    // receiver side: random stalls plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 13);
        end
    end

    always @(posedge aclk) begin
        logic [STATUS_W-1:0] est;
        logic [MET_W-1:0]    emet, msk, ev, av;
        if (aresetn && m_tvalid && m_tready) begin
            if (status_q.size() == 0) begin
                $display("%0t: result transfer with nothing expected, status %0d",
                         $time, m_tuser);
                fail_count++;
            end else begin
                est  = status_q.pop_front();
                emet = metrics_q.pop_front();
                if (m_tuser !== est) begin
                    $display("%0t: status expected %0d actual %0d", $time, est, m_tuser);
                    fail_count++;
                end
                for (int i = 0; i < NFIELD; i++) begin
                    msk = (MET_W'(1) << FWID[i]) - 1;
                    ev  = (emet >> FOFF[i]) & msk;
                    av  = (m_tdata[MET_W-1:0] >> FOFF[i]) & msk;
                    if (av !== ev) begin
                        $display("%0t: %s expected %0h actual %0h", $time, FNAME[i], ev, av);
                        fail_count++;
                    end
                end
                if (m_tdata[M_TDATA_W-1:MET_W] !== '0) begin
                    $display("%0t: fill bits expected 0 actual %0h", $time,
                             m_tdata[M_TDATA_W-1:MET_W]);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_directed();
        send_trade(32'd100000, 32'd10, 1'b1);
        send_book(32'd0, 32'd5, 32'd100, 32'd5);
        send_book(32'd100, 32'd0, 32'd200, 32'd5);
        send_book(32'd100, 32'd5, 32'd0, 32'd5);
        send_book(32'd100, 32'd5, 32'd200, 32'd0);
        send_book(32'd300, 32'd5, 32'd200, 32'd5);
        send_book(32'd200, 32'd5, 32'd200, 32'd5);
        send_book(32'd1000000, 32'd40, 32'd1000100, 32'd60);
        send_book(32'd1000000, 32'd70, 32'd1000100, 32'd20);
        send_trade(32'd1000050, 32'd15, 1'b1);
        send_book(32'd1000020, 32'd30, 32'd1000200, 32'd90);
        send_trade(32'd999000, 32'd25, 1'b0);
        send_trade(32'd1000300, 32'd0, 1'b1);
        send_book(32'd1, 32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFF);
        send_book(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1);
        send_trade(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_trade(32'd0, 32'hFFFF_FFFF, 1'b1);
        send_book(32'd1, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_book(32'd1, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_trade(32'h8000_0000, 32'h8000_0000, 1'b1);
        send_book(32'hFFFF_FFFF, 32'd7, 32'hFFFF_FFFF, 32'd7);
        wait_drained();
    endtask

    task automatic random_event();
        int unsigned pick, spr;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            send_event(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, 1'($urandom_range(0, 1)));
        end else if (pick < 14) begin
            send_book($urandom_range(0, 3) == 0 ? 32'd0 : $urandom, $urandom_range(0, 1) ?
                      32'd0 : $urandom, $urandom, $urandom_range(0, 1) ? 32'd0 : $urandom);
        end else if (pick < 62) begin
            if ($urandom_range(0, 4) != 0) begin
                if ($urandom_range(0, 1)) walk_px += $urandom_range(0, 500);
                else walk_px -= $urandom_range(0, 500);
                if (walk_px < 32'd1000 || walk_px > 32'hFFFF_0000)
                    walk_px = $urandom_range(1000, 32'hFFFF_0000);
            end
            spr = $urandom_range(1, 300);
            send_book(walk_px, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 5000),
                      walk_px + spr,
                      $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 5000));
        end else begin
            send_trade($urandom_range(0, 9) == 0 ? $urandom : walk_px + $urandom_range(0, 600)
                       - 300, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3000),
                       1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_random(input int count);
        repeat (count) random_event();
    endtask

    task automatic test_no_idle();
        calm = 1'b1;
        repeat (150) random_event();
        calm = 1'b0;
    endtask

    task automatic test_output_hold();
        hold_cycles = 3000;
        repeat (12) random_event();
    endtask

    task automatic test_sender_pause();
        repeat (20) random_event();
        wait_drained();
        repeat (40) random_event();
    endtask

    initial begin
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= 1'b0;
        fail_count  = 0;
        calm        = 1'b0;
        hold_cycles = 0;
        walk_px     = $urandom_range(1000, 32'hF000_0000);
        bk_bid_px = '0; bk_bid_qty = '0; bk_ask_px = '0; bk_ask_qty = '0;
        bk_valid = 1'b0; mid2_prev = '0; trade_mid2_prev = '0;
        sq_ret_sum = '0; px_vol_sum = '0; vol_sq_sum = '0;
        p_micro = '0; p_mid = '0; p_diff = '0; p_imb = '0; p_vol = '0;
        p_samples = '0; p_books = '0; p_degen = '0; p_trades = '0;
        p_spread = '0; p_lambda = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(400);
        test_output_hold();
        test_no_idle();
        test_sender_pause();
        test_random(380);
        wait_drained();
        repeat (50) @(posedge aclk);
        if (fail_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial begin
        #600_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
